// File: rtl/core/wps_pkg.sv
// Shared types, constants, microcode and arithmetic helpers of the windkessel pressure step.
`timescale 1ns / 1ps

package wps_pkg;

  localparam int VW   = 32;      // value width
  localparam int FB   = 16;      // fraction bits
  localparam int CW   = VW - 1;  // register and time step width
  localparam int SW   = 32;      // step index width
  localparam int DW   = VW + FB; // dividend width
  localparam int PC_W = 6;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW + 1);

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] ONE  = VW'(1) << FB;
  localparam logic [CW-1:0] CFG_RESET = CW'(1) << FB;
  localparam logic [DW:0]   LIM_POS = {{(DW-VW+1){1'b0}}, 1'b0, {(VW-1){1'b1}}};
  localparam logic [DW:0]   LIM_NEG = LIM_POS + (DW+1)'(1);

  typedef logic signed [VW-1:0] val_t;

  typedef enum logic [1:0] {
    CFG_RR  = 2'd0,
    CFG_RCH = 2'd1,
    CFG_CC  = 2'd2,
    CFG_RHO = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SRC_QN   = 4'd0,
    SRC_MEAN = 4'd1,
    SRC_DT   = 4'd2,
    SRC_RR   = 4'd3,
    SRC_RCH  = 4'd4,
    SRC_CC   = 4'd5,
    SRC_RHO  = 4'd6,
    SRC_ONE  = 4'd7,
    SRC_FP   = 4'd8,
    SRC_FP2  = 4'd9,
    SRC_PP   = 4'd10,
    SRC_PP2  = 4'd11,
    SRC_T0   = 4'd12,
    SRC_T1   = 4'd13,
    SRC_T2   = 4'd14,
    SRC_T3   = 4'd15
  } src_e;

  typedef enum logic [2:0] {
    DST_T0  = 3'd0,
    DST_T1  = 3'd1,
    DST_T2  = 3'd2,
    DST_T3  = 3'd3,
    DST_PP  = 3'd4,
    DST_OUT = 3'd5
  } dst_e;

  typedef enum logic [1:0] {
    NXT_SEQ    = 2'd0,
    NXT_BRANCH = 2'd1,
    NXT_END    = 2'd2
  } nxt_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e dst;
    nxt_e nxt;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   shift;
    logic   start;
    instr_t instr;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic changed;
    logic second;
    logic out_free;
  } sts_t;

  localparam logic [PC_W-1:0] PC_PRE = PC_W'(0);
  localparam logic [PC_W-1:0] PC_SO  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_FO  = PC_W'(25);

  function automatic instr_t mk(op_e op, src_e a, src_e b, dst_e dst, nxt_e nxt);
    instr_t i;
    i.op = op;
    i.a = a;
    i.b = b;
    i.dst = dst;
    i.nxt = nxt;
    return i;
  endfunction

  // Microcode: pressure history update, second-order program, first-order program.
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OP_MUL, SRC_MEAN, SRC_RHO, DST_PP, NXT_BRANCH);
      // second order
      6'd1:  i = mk(OP_MUL, SRC_CC,  SRC_RR,  DST_T0, NXT_SEQ);
      6'd2:  i = mk(OP_ADD, SRC_DT,  SRC_DT,  DST_T1, NXT_SEQ);
      6'd3:  i = mk(OP_DIV, SRC_T0,  SRC_T1,  DST_T1, NXT_SEQ);
      6'd4:  i = mk(OP_ADD, SRC_QN,  SRC_QN,  DST_T2, NXT_SEQ);
      6'd5:  i = mk(OP_ADD, SRC_T2,  SRC_QN,  DST_T2, NXT_SEQ);
      6'd6:  i = mk(OP_ADD, SRC_T2,  SRC_FP2, DST_T2, NXT_SEQ);
      6'd7:  i = mk(OP_ADD, SRC_FP,  SRC_FP,  DST_T3, NXT_SEQ);
      6'd8:  i = mk(OP_ADD, SRC_T3,  SRC_T3,  DST_T3, NXT_SEQ);
      6'd9:  i = mk(OP_SUB, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd10: i = mk(OP_MUL, SRC_T2,  SRC_T1,  DST_T2, NXT_SEQ);
      6'd11: i = mk(OP_MUL, SRC_T2,  SRC_RCH, DST_T2, NXT_SEQ);
      6'd12: i = mk(OP_ADD, SRC_RCH, SRC_RR,  DST_T3, NXT_SEQ);
      6'd13: i = mk(OP_MUL, SRC_T3,  SRC_QN,  DST_T3, NXT_SEQ);
      6'd14: i = mk(OP_ADD, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd15: i = mk(OP_ADD, SRC_PP,  SRC_PP,  DST_T3, NXT_SEQ);
      6'd16: i = mk(OP_ADD, SRC_T3,  SRC_T3,  DST_T3, NXT_SEQ);
      6'd17: i = mk(OP_SUB, SRC_PP2, SRC_T3,  DST_T3, NXT_SEQ);
      6'd18: i = mk(OP_MUL, SRC_T3,  SRC_T1,  DST_T3, NXT_SEQ);
      6'd19: i = mk(OP_SUB, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd20: i = mk(OP_ADD, SRC_T1,  SRC_T1,  DST_T3, NXT_SEQ);
      6'd21: i = mk(OP_ADD, SRC_T3,  SRC_T1,  DST_T3, NXT_SEQ);
      6'd22: i = mk(OP_ADD, SRC_ONE, SRC_T3,  DST_T3, NXT_SEQ);
      6'd23: i = mk(OP_DIV, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd24: i = mk(OP_DIV, SRC_T2,  SRC_RHO, DST_OUT, NXT_END);
      // first order
      6'd25: i = mk(OP_MUL, SRC_CC,  SRC_RR,  DST_T0, NXT_SEQ);
      6'd26: i = mk(OP_DIV, SRC_T0,  SRC_DT,  DST_T1, NXT_SEQ);
      6'd27: i = mk(OP_SUB, SRC_QN,  SRC_FP,  DST_T2, NXT_SEQ);
      6'd28: i = mk(OP_MUL, SRC_T2,  SRC_T1,  DST_T2, NXT_SEQ);
      6'd29: i = mk(OP_MUL, SRC_T2,  SRC_RCH, DST_T2, NXT_SEQ);
      6'd30: i = mk(OP_ADD, SRC_RCH, SRC_RR,  DST_T3, NXT_SEQ);
      6'd31: i = mk(OP_MUL, SRC_T3,  SRC_QN,  DST_T3, NXT_SEQ);
      6'd32: i = mk(OP_ADD, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd33: i = mk(OP_MUL, SRC_PP,  SRC_T1,  DST_T3, NXT_SEQ);
      6'd34: i = mk(OP_ADD, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd35: i = mk(OP_ADD, SRC_ONE, SRC_T1,  DST_T3, NXT_SEQ);
      6'd36: i = mk(OP_DIV, SRC_T2,  SRC_T3,  DST_T2, NXT_SEQ);
      6'd37: i = mk(OP_DIV, SRC_T2,  SRC_RHO, DST_OUT, NXT_END);
      default: i = mk(OP_ADD, SRC_T0, SRC_T0, DST_OUT, NXT_END);
    endcase
    return i;
  endfunction

  // Rounded magnitude to signed value with clipping; msb of the result is the clip flag.
  function automatic logic [VW:0] finish(logic [DW:0] m, logic neg);
    logic [DW:0] lim;
    logic [VW:0] r;
    lim = neg ? LIM_NEG : LIM_POS;
    if (m > lim) begin
      r = {1'b1, (neg ? VMIN : VMAX)};
    end else if (neg) begin
      r = {1'b0, VW'(0) - m[VW-1:0]};
    end else begin
      r = {1'b0, m[VW-1:0]};
    end
    return r;
  endfunction

  // Saturate a one-bit-grown sum; msb of the result is the clip flag.
  function automatic logic [VW:0] clip_sum(logic [VW:0] s);
    logic [VW:0] r;
    if (s[VW] != s[VW-1]) begin
      r = {1'b1, (s[VW] ? VMIN : VMAX)};
    end else begin
      r = {1'b0, s[VW-1:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/wps_if.sv
// Request channel interfaces of the windkessel pressure step.
`timescale 1ns / 1ps

interface wps_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        flow_sum;
  logic signed [31:0]        mean_boundary_value;
  logic [31:0]               step_index;
  logic [30:0]               time_step;

  modport source (output valid, flow_sum, mean_boundary_value, step_index, time_step,
                  input ready);
  modport sink (input valid, flow_sum, mean_boundary_value, step_index, time_step,
                output ready);
  modport monitor (input valid, ready, flow_sum, mean_boundary_value, step_index,
                   time_step);
endinterface

interface wps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] boundary_value;
  logic               saturated;

  modport source (output valid, boundary_value, saturated, input ready);
  modport sink (input valid, boundary_value, saturated, output ready);
  modport monitor (input valid, ready, boundary_value, saturated);
endinterface

// File: rtl/core/windkessel_pressure_step.sv
// Top level of the three-element windkessel boundary pressure update.
// Each request runs the history update if the step index changed, then the second- or
//   first-order program; each program holds three 48-step divides, and a zero divisor
//   skips the divide steps.
// Throughput: one request at a time; the next is taken while the result waits.
// Reset (rst_ni low, async): registers return to 1.0, history to zero, step to none.
`timescale 1ns / 1ps

module windkessel_pressure_step (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  wps_in_if.sink                 in_i,
  wps_out_if.source              out_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [wps_pkg::CW-1:0] cfg_data_i
);

  wps_pkg::cmd_t cmd;   // sequencer to datapath: load, history shift, op start
  wps_pkg::sts_t sts;   // datapath to sequencer: op done, step changed, order, output free
  logic          in_ready;

  // Sequencer walks the microcode: history update (if the step changed),
  // then the first- or second-order program; last op writes the output register.
  wps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: config, history, scratch registers, one saturating adder,
  // one 32x32 multiplier and one radix-2 divider shared by all ops.
  wps_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .flow_sum_i            (in_i.flow_sum),
    .mean_boundary_value_i (in_i.mean_boundary_value),
    .step_index_i          (in_i.step_index),
    .time_step_i           (in_i.time_step),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_valid_o           (out_o.valid),
    .out_ready_i           (out_o.ready),
    .boundary_value_o      (out_o.boundary_value),
    .saturated_o           (out_o.saturated)
  );

  assign in_i.ready = in_ready;

endmodule

// File: rtl/core/wps_ctrl.sv
// Microcode sequencer of the windkessel pressure step.
`timescale 1ns / 1ps

module wps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wps_pkg::sts_t sts_i,
  output wps_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [wps_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [wps_pkg::PC_W-1:0]    pc_order;

  assign pc_order = sts_i.second ? wps_pkg::PC_SO : wps_pkg::PC_FO;

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    cmd_o = '0;
    cmd_o.instr = wps_pkg::prog(pc_q);
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = sts_i.changed;
        pc_d = sts_i.changed ? wps_pkg::PC_PRE : pc_order;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        // the last op writes the output register, which must be free
        if (cmd_o.instr.dst != wps_pkg::DST_OUT || sts_i.out_free) begin
          cmd_o.start = 1'b1;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          case (cmd_o.instr.nxt)
            wps_pkg::NXT_SEQ: begin
              pc_d = pc_q + wps_pkg::PC_W'(1);
              state_d = ST_ISSUE;
            end
            wps_pkg::NXT_BRANCH: begin
              pc_d = pc_order;
              state_d = ST_ISSUE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/core/wps_datapath.sv
// Registers, shared multiplier and radix-2 divider of the windkessel pressure step.
`timescale 1ns / 1ps

module wps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [wps_pkg::CW-1:0]        cfg_data_i,
  input  logic signed [wps_pkg::VW-1:0] flow_sum_i,
  input  logic signed [wps_pkg::VW-1:0] mean_boundary_value_i,
  input  logic [wps_pkg::SW-1:0]        step_index_i,
  input  logic [wps_pkg::CW-1:0]        time_step_i,
  input  wps_pkg::cmd_t                 cmd_i,
  output wps_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [wps_pkg::VW-1:0] boundary_value_o,
  output logic                          saturated_o
);

  localparam int VW = wps_pkg::VW;
  localparam int DW = wps_pkg::DW;

  // configuration
  logic [wps_pkg::CW-1:0] rr_q, rch_q, cc_q, rho_q;
  // latched request and history
  wps_pkg::val_t          qn_q, mean_q, pp_q, pp2_q, fp_q, fp2_q;
  logic [wps_pkg::SW-1:0] step_q, last_q;
  logic [wps_pkg::CW-1:0] dt_q;
  // scratch
  wps_pkg::val_t          t0_q, t1_q, t2_q, t3_q;
  // op unit
  wps_pkg::val_t          opa_q, opb_q;
  wps_pkg::op_e           op_q;
  wps_pkg::dst_e          dst_q;
  logic                   act_q;
  logic [wps_pkg::CNT_W-1:0] cnt_q;
  logic [2*VW-1:0]        prod_q;
  logic                   neg_q;
  logic [VW-1:0]          rem_q, dvs_q;
  logic [DW-1:0]          num_q, quo_q;
  logic                   clip_q;
  logic                   out_valid_q, out_sat_q;
  wps_pkg::val_t          out_val_q;

  wps_pkg::val_t          src_a, src_b;
  logic [VW-1:0]          mag_a, mag_b;
  logic [VW:0]            sum_ext, sum_res, fin_res;
  logic [2*VW:0]          prod_rnd;
  logic [DW:0]            quo_rnd;
  logic [VW:0]            rem_try;
  logic                   rem_ge;
  logic                   res_wr;
  logic [VW:0]            res;

  function automatic wps_pkg::val_t pick(wps_pkg::src_e s,
      wps_pkg::val_t qn, wps_pkg::val_t mean, logic [wps_pkg::CW-1:0] dt,
      logic [wps_pkg::CW-1:0] rr, logic [wps_pkg::CW-1:0] rch,
      logic [wps_pkg::CW-1:0] cc, logic [wps_pkg::CW-1:0] rho,
      wps_pkg::val_t fp, wps_pkg::val_t fp2, wps_pkg::val_t pp, wps_pkg::val_t pp2,
      wps_pkg::val_t t0, wps_pkg::val_t t1, wps_pkg::val_t t2, wps_pkg::val_t t3);
    wps_pkg::val_t v;
    case (s)
      wps_pkg::SRC_QN:   v = qn;
      wps_pkg::SRC_MEAN: v = mean;
      wps_pkg::SRC_DT:   v = {1'b0, dt};
      wps_pkg::SRC_RR:   v = {1'b0, rr};
      wps_pkg::SRC_RCH:  v = {1'b0, rch};
      wps_pkg::SRC_CC:   v = {1'b0, cc};
      wps_pkg::SRC_RHO:  v = {1'b0, rho};
      wps_pkg::SRC_ONE:  v = wps_pkg::ONE;
      wps_pkg::SRC_FP:   v = fp;
      wps_pkg::SRC_FP2:  v = fp2;
      wps_pkg::SRC_PP:   v = pp;
      wps_pkg::SRC_PP2:  v = pp2;
      wps_pkg::SRC_T0:   v = t0;
      wps_pkg::SRC_T1:   v = t1;
      wps_pkg::SRC_T2:   v = t2;
      default:           v = t3;
    endcase
    return v;
  endfunction

  assign src_a = pick(cmd_i.instr.a, qn_q, mean_q, dt_q, rr_q, rch_q, cc_q, rho_q,
                      fp_q, fp2_q, pp_q, pp2_q, t0_q, t1_q, t2_q, t3_q);
  assign src_b = pick(cmd_i.instr.b, qn_q, mean_q, dt_q, rr_q, rch_q, cc_q, rho_q,
                      fp_q, fp2_q, pp_q, pp2_q, t0_q, t1_q, t2_q, t3_q);

  assign mag_a = opa_q[VW-1] ? VW'(0) - opa_q : opa_q;
  assign mag_b = opb_q[VW-1] ? VW'(0) - opb_q : opb_q;

  assign sum_ext = (op_q == wps_pkg::OP_SUB) ? {opa_q[VW-1], opa_q} - {opb_q[VW-1], opb_q}
                                              : {opa_q[VW-1], opa_q} + {opb_q[VW-1], opb_q};
  assign sum_res = wps_pkg::clip_sum(sum_ext);

  // round half away from zero, drop fraction bits
  assign prod_rnd = {1'b0, prod_q} + ((2*VW+1)'(1) << (wps_pkg::FB - 1));
  assign rem_try  = {rem_q, num_q[DW-1]};
  assign rem_ge   = (rem_try >= {1'b0, dvs_q});
  assign quo_rnd  = {1'b0, quo_q} + (DW+1)'({rem_q, 1'b0} >= {1'b0, dvs_q});
  assign fin_res  = (op_q == wps_pkg::OP_MUL)
                    ? wps_pkg::finish(prod_rnd[2*VW:wps_pkg::FB], neg_q)
                    : wps_pkg::finish(quo_rnd, neg_q);

  always_comb begin
    res_wr = 1'b0;
    res = sum_res;
    if (act_q) begin
      case (op_q)
        wps_pkg::OP_ADD, wps_pkg::OP_SUB: begin
          res_wr = 1'b1;
        end
        wps_pkg::OP_MUL: begin
          res_wr = (cnt_q != '0);
          res = fin_res;
        end
        default: begin
          if (cnt_q == '0 && opb_q == '0) begin
            // zero divisor: sign of the dividend picks the rail, a zero dividend gives zero
            res_wr = 1'b1;
            res = {1'b1, (opa_q[VW-1] ? wps_pkg::VMIN
                          : (opa_q == '0 ? VW'(0) : wps_pkg::VMAX))};
          end else begin
            res_wr = (cnt_q == wps_pkg::DIV_LAST);
            res = fin_res;
          end
        end
      endcase
    end
  end

  assign sts_o.done     = res_wr;
  assign sts_o.changed  = (step_q != last_q);
  assign sts_o.second   = (step_q > wps_pkg::SW'(1));
  assign sts_o.out_free = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q <= wps_pkg::CFG_RESET;
      rch_q <= wps_pkg::CFG_RESET;
      cc_q <= wps_pkg::CFG_RESET;
      rho_q <= wps_pkg::CFG_RESET;
      last_q <= '1;
      pp_q <= '0;
      pp2_q <= '0;
      fp_q <= '0;
      fp2_q <= '0;
      act_q <= 1'b0;
      cnt_q <= '0;
      clip_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (wps_pkg::cfg_e'(cfg_idx_i))
          wps_pkg::CFG_RR:  rr_q <= cfg_data_i;
          wps_pkg::CFG_RCH: rch_q <= cfg_data_i;
          wps_pkg::CFG_CC:  cc_q <= cfg_data_i;
          wps_pkg::CFG_RHO: rho_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        clip_q <= 1'b0;
      end
      if (cmd_i.shift) begin
        last_q <= step_q;
        pp2_q <= pp_q;
        fp2_q <= fp_q;
        fp_q <= qn_q;
      end
      if (cmd_i.start) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (res_wr) begin
        act_q <= 1'b0;
      end else if (act_q) begin
        cnt_q <= cnt_q + wps_pkg::CNT_W'(1);
      end
      if (res_wr) begin
        clip_q <= clip_q | res[VW];
        if (dst_q == wps_pkg::DST_PP) begin
          pp_q <= res[VW-1:0];
        end
      end
      if (res_wr && dst_q == wps_pkg::DST_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qn_q <= flow_sum_i;
      mean_q <= mean_boundary_value_i;
      step_q <= step_index_i;
      dt_q <= time_step_i;
    end
    if (cmd_i.start) begin
      opa_q <= src_a;
      opb_q <= src_b;
      op_q <= cmd_i.instr.op;
      dst_q <= cmd_i.instr.dst;
    end
    if (act_q && cnt_q == '0) begin
      prod_q <= mag_a * mag_b;
      neg_q <= opa_q[VW-1] ^ opb_q[VW-1];
      rem_q <= '0;
      dvs_q <= mag_b;
      num_q <= {mag_a, {wps_pkg::FB{1'b0}}};
      quo_q <= '0;
    end else if (act_q && op_q == wps_pkg::OP_DIV && !res_wr) begin
      // one quotient bit per cycle, restoring
      rem_q <= rem_ge ? VW'(rem_try - {1'b0, dvs_q}) : rem_try[VW-1:0];
      quo_q <= {quo_q[DW-2:0], rem_ge};
      num_q <= {num_q[DW-2:0], 1'b0};
    end
    if (res_wr) begin
      unique case (dst_q)
        wps_pkg::DST_T0: t0_q <= res[VW-1:0];
        wps_pkg::DST_T1: t1_q <= res[VW-1:0];
        wps_pkg::DST_T2: t2_q <= res[VW-1:0];
        wps_pkg::DST_T3: t3_q <= res[VW-1:0];
        wps_pkg::DST_OUT: begin
          out_val_q <= res[VW-1:0];
          out_sat_q <= clip_q | res[VW];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign boundary_value_o = out_val_q;
  assign saturated_o = out_sat_q;

endmodule

// File: rtl/core/wps_checker.sv
// Port-level assertions of the windkessel pressure step, bound to the top level.
`timescale 1ns / 1ps

module wps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [wps_pkg::VW-1:0] out_value_i,
  input logic                          out_sat_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_sat_i))
    else $error("stalled result changed");

  // one request in flight: ready drops after a request is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // a new result only comes from work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a request in progress");

endmodule

bind windkessel_pressure_step wps_checker u_wps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.boundary_value),
  .out_sat_i   (out_o.saturated)
);

// File: bench/tb.sv
// Self-checking bench for the windkessel boundary pressure update.
`timescale 1ns / 1ps

module tb;

  localparam int     WATCHDOG_LIMIT = 40000;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -QMAX - 1;
  localparam longint Q_ONE = 64'sd65536;

  typedef struct {
    wps_pkg::val_t value;
    logic          sat;
  } pres_t;

  // One directed row; typed rows carry an expectation written by hand.
  typedef struct {
    wps_pkg::val_t flow;
    wps_pkg::val_t mean;
    logic [31:0]   step;
    logic [30:0]   dt;
    bit            typed;
    wps_pkg::val_t bv;
    logic          sat;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [wps_pkg::CW-1:0] cfg_data_i;

  wps_in_if  in_if ();
  wps_out_if out_if ();

  windkessel_pressure_step u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Pressure predictor state: registers, step tracking and history.
  longint      r_dist, r_char, c_art, rho;
  logic [31:0] last_step;
  longint      p_prev, p_prev2, q_prev, q_prev2;
  bit          clipped;

  pres_t  pressure_q[$];
  int     errors = 0;
  int     idle_mode = 0;  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
  int     quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Q16.16 saturating arithmetic, every intermediate clipped to 32 bits signed
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q(longint v);
    if (v > QMAX) begin
      clipped = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      clipped = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic longint add_q(longint a, longint b);
    return clamp_q(a + b);
  endfunction

  function automatic longint sub_q(longint a, longint b);
    return clamp_q(a - b);
  endfunction

  function automatic longint unsigned mag_q(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  // Rounded magnitude back to a signed value, clipped against the signed limits.
  function automatic longint signed_q(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) begin
      clipped = 1'b1;
      return neg ? QMIN : QMAX;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned p;
    p = (mag_q(a) * mag_q(b) + 64'd32768) >> wps_pkg::FB;
    return signed_q(p, (a < 0) != (b < 0));
  endfunction

  // Quotient rounds half away from zero; a zero divisor saturates by sign.
  function automatic longint div_q(longint a, longint b);
    longint unsigned n, d, q, r;
    if (b == 0) begin
      clipped = 1'b1;
      return (a > 0) ? QMAX : ((a < 0) ? QMIN : 0);
    end
    n = mag_q(a) << wps_pkg::FB;
    d = mag_q(b);
    q = n / d;
    r = n % d;
    if (r >= d - r) q++;
    return signed_q(q, (a < 0) != (b < 0));
  endfunction

  function automatic longint x3_q(longint a);
    return add_q(add_q(a, a), a);
  endfunction

  function automatic longint x4_q(longint a);
    longint t;
    t = add_q(a, a);
    return add_q(t, t);
  endfunction

  // One boundary update: history shift on a new step, then BDF1 or BDF2.
  function automatic pres_t predict_pressure(wps_pkg::val_t flow, wps_pkg::val_t mean,
                                             logic [31:0] step, logic [30:0] dt);
    longint qn, dtv, k, g, t, num, den, pn;
    pres_t  r;
    clipped = 1'b0;
    qn  = flow;
    dtv = dt;
    if (step != last_step) begin
      last_step = step;
      p_prev2   = p_prev;
      p_prev    = mul_q(mean, rho);
      q_prev2   = q_prev;
      q_prev    = qn;
    end
    k = mul_q(c_art, r_dist);
    if (step > 32'd1) begin
      g   = div_q(k, add_q(dtv, dtv));
      t   = add_q(x3_q(qn), q_prev2);
      t   = sub_q(t, x4_q(q_prev));
      num = mul_q(mul_q(t, g), r_char);
      num = add_q(num, mul_q(add_q(r_char, r_dist), qn));
      t   = sub_q(p_prev2, x4_q(p_prev));
      num = sub_q(num, mul_q(t, g));
      den = add_q(Q_ONE, x3_q(g));
    end else begin
      g   = div_q(k, dtv);
      num = mul_q(mul_q(sub_q(qn, q_prev), g), r_char);
      num = add_q(num, mul_q(add_q(r_char, r_dist), qn));
      num = add_q(num, mul_q(p_prev, g));
      den = add_q(Q_ONE, g);
    end
    pn      = div_q(num, den);
    r.value = wps_pkg::val_t'(div_q(pn, rho));
    r.sat   = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (idle_mode)
      1:       return $urandom_range(99) < 81;
      3:       return $urandom_range(99) < 28;
      default: return 1'b0;
    endcase
  endfunction

  // Drives one request and waits for the handshake; valid stays high on return
  // so back-to-back requests need no lowering in between.
  task automatic send_request(stim_t s);
    pres_t p;
    if (sender_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while (sender_gap()) @(posedge clk_i);
    end
    in_if.valid               <= 1'b1;
    in_if.flow_sum            <= s.flow;
    in_if.mean_boundary_value <= s.mean;
    in_if.step_index          <= s.step;
    in_if.time_step           <= s.dt;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    p = predict_pressure(s.flow, s.mean, s.step, s.dt);
    if (s.typed) begin
      p.value = s.bv;
      p.sat   = s.sat;
    end
    pressure_q.push_back(p);
  endtask

  // Lower valid, then let every pending pressure come back before touching registers.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pressure_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [30:0] rr, logic [30:0] rch, logic [30:0] cc,
                            logic [30:0] dens);
    logic [30:0] vals[4];
    vals = '{rr, rch, cc, dens};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    r_dist = rr;
    r_char = rch;
    c_art  = cc;
    rho    = dens;
  endtask

  function automatic stim_t row(wps_pkg::val_t flow, wps_pkg::val_t mean, logic [31:0] step,
                                logic [30:0] dt);
    stim_t s;
    s.flow  = flow;
    s.mean  = mean;
    s.step  = step;
    s.dt    = dt;
    s.typed = 1'b0;
    s.bv    = '0;
    s.sat   = 1'b0;
    return s;
  endfunction

  // Mostly small magnitudes so the pressure stays in range; the rest full scale.
  function automatic wps_pkg::val_t rand_val();
    if ($urandom_range(99) < 70) begin
      return wps_pkg::val_t'($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    end
    return wps_pkg::val_t'($urandom);
  endfunction

  function automatic logic [30:0] rand_reg(int kind);
    case (kind)
      0:       return 31'($urandom_range(32'h0010_0000, 32'h0000_1000));
      default: return 31'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, scoreboard and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pres_t e;
    if (out_if.valid && out_if.ready) begin
      if (pressure_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pressure %0d sat %0b", $time, out_if.boundary_value,
                 out_if.saturated);
      end else begin
        e = pressure_q.pop_front();
        if (out_if.boundary_value !== e.value || out_if.saturated !== e.sat) begin
          errors++;
          $display("%0t: pressure mismatch expected %0d sat %0b actual %0d sat %0b",
                   $time, e.value, e.sat, out_if.boundary_value, out_if.saturated);
        end
      end
    end
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    case (idle_mode)
      2:       out_if.ready <= ($urandom_range(99) >= 81);
      3:       out_if.ready <= ($urandom_range(99) >= 28);
      default: out_if.ready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_t       dir_tab[$];
    stim_t       s;
    logic [31:0] step;

    in_if.valid               = 1'b0;
    in_if.flow_sum            = '0;
    in_if.mean_boundary_value = '0;
    in_if.step_index          = '0;
    in_if.time_step           = '0;
    out_if.ready              = 1'b1;
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = wps_pkg::CFG_RR;
    cfg_data_i                = '0;

    r_dist    = wps_pkg::CFG_RESET;
    r_char    = wps_pkg::CFG_RESET;
    c_art     = wps_pkg::CFG_RESET;
    rho       = wps_pkg::CFG_RESET;
    last_step = '1;
    p_prev    = 0;
    p_prev2   = 0;
    q_prev    = 0;
    q_prev2   = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with reset registers: zero history gives a zero pressure.
    s = row('0, '0, 32'd0, 31'h1_0000);
    s.typed = 1'b1;
    dir_tab.push_back(s);
    s.typed = 1'b1;  // same step again: no history shift, still zero
    dir_tab.push_back(s);
    dir_tab.push_back(row(wps_pkg::VMAX, wps_pkg::VMAX, 32'd1, 31'h1_0000));
    dir_tab.push_back(row(wps_pkg::VMIN, wps_pkg::VMIN, 32'd2, 31'h1_0000));
    dir_tab.push_back(row(wps_pkg::VMAX, wps_pkg::VMIN, 32'd3, 31'd1));
    dir_tab.push_back(row(wps_pkg::VMIN, wps_pkg::VMAX, 32'd4, 31'h7FFF_FFFF));
    dir_tab.push_back(row(32'sh1_0000, 32'sh2_0000, 32'd5, 31'd0));  // zero time step
    dir_tab.push_back(row(-32'sh1_0000, 32'sh8000, 32'd5, 31'h1_0000));
    dir_tab.push_back(row(32'sh3_0000, 32'sh1_0000, 32'hFFFF_FFFE, 31'h0290));
    dir_tab.push_back(row(32'sh0_8000, -32'sh1_0000, 32'hFFFF_FFFF, 31'h1_0000));
    dir_tab.push_back(row(32'sd1, -32'sd1, 32'd1, 31'd1));
    dir_tab.push_back(row(-32'sd1, 32'sd1, 32'd2, 31'd2));
    dir_tab.push_back(row('0, '0, 32'd6, 31'h7FFF_FFFF));
    dir_tab.push_back(row(32'sh1234_5678, -32'sh5555_5555, 32'd7, 31'h2AAA_AAAA));
    dir_tab.push_back(row(-32'sh0002_0000, 32'sh0010_0000, 32'd0, 31'h0000_4000));
    dir_tab.push_back(row(32'sh0004_0000, 32'sh0020_0000, 32'd8, 31'h0000_4000));
    foreach (dir_tab[i]) send_request(dir_tab[i]);
    drain();

    // Random phases: each sets registers, then runs step sequences under one idle mode.
    step = 32'd0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(wps_pkg::CFG_RESET, wps_pkg::CFG_RESET, wps_pkg::CFG_RESET,
                      wps_pkg::CFG_RESET);
        1: write_regs('1, '1, '1, '1);
        2: write_regs(31'd1, 31'd1, 31'd1, 31'd1);
        3: write_regs(rand_reg(1), rand_reg(1), rand_reg(1), rand_reg(1));
        5: write_regs(rand_reg(0), rand_reg(0), rand_reg(0), '0);  // zero density
        default: write_regs(rand_reg(0), rand_reg(0), rand_reg(0), rand_reg(0));
      endcase
      idle_mode = ph % 4;
      for (int n = 0; n < ((ph == 5) ? 40 : 260); n++) begin
        // Mostly advancing steps; some repeats, restarts and jumps.
        case ($urandom_range(99)) inside
          [0:79]:  step = step + 1;
          [80:89]: ;
          [90:94]: step = $urandom_range(1);
          default: step = $urandom;
        endcase
        s = row(rand_val(), rand_val(), step,
                ($urandom_range(9) == 0) ? 31'($urandom)
                                         : 31'($urandom_range(32'h0004_0000, 32'h0000_0400)));
        send_request(s);
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wps_pkg.sv
rtl/core/wps_if.sv
rtl/core/wps_ctrl.sv
rtl/core/wps_datapath.sv
rtl/core/windkessel_pressure_step.sv
rtl/core/wps_checker.sv
bench/tb.sv
